@@ sv/lsch_pkg.sv @@
`default_nettype none

package lsch_pkg;

  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned ENTRY_ID_W = 4;
  localparam int unsigned TICKET_W   = 8;
  localparam int unsigned RND_W      = 32;
  localparam int unsigned TOTAL_W    = 12;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BITCNT_W   = $clog2(RND_W + 1);
  // wide enough to hold any entry id and a table depth of up to 511
  localparam int unsigned ID_EXT_W   = 9;

  localparam int unsigned MAX_TICKETS = 255;

  localparam logic [REQ_TYPE_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_DRAW   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_USED   = 2'd2,
    ST_ABSENT = 2'd3
  } lsch_status_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic walk;
    logic div_run;
    logic result_load;
  } lsch_cmd_t;

  typedef struct packed {
    logic is_draw;
    logic scan_done;
    logic total_zero;
    logic div_done;
    logic found;
  } lsch_sts_t;

endpackage

`default_nettype wire

@@ sv/lsch_if.sv @@
`default_nettype none

interface lsch_req_if
  import lsch_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [ENTRY_ID_W-1:0] entry_id;
  logic [TICKET_W-1:0]   ticket_count;
  logic [RND_W-1:0]      random_value;

  modport source (output valid, output req_type, output entry_id, output ticket_count,
                  output random_value, input ready);
  modport sink   (input valid, input req_type, input entry_id, input ticket_count,
                  input random_value, output ready);
endinterface

interface lsch_rsp_if
  import lsch_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ENTRY_ID_W-1:0] winner_id;
  logic                  winner_found;
  logic [TOTAL_W-1:0]    ticket_sum;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, output winner_id, output winner_found,
                  output ticket_sum, output status, input ready);
  modport sink   (input valid, input winner_id, input winner_found,
                  input ticket_sum, input status, output ready);
endinterface

`default_nettype wire

@@ sv/lsch_ctrl.sv @@
`default_nettype none

module lsch_ctrl
  import lsch_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output lsch_cmd_t      cmd_o,
  input  wire lsch_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SUM,
    S_DIV,
    S_WALK,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.is_draw) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SUM;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SUM: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.total_zero ? S_FINISH : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_run = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.walk     = 1'b1;
        if (sts_i.found || sts_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/lsch_dp.sv @@
`default_nettype none

module lsch_dp
  import lsch_pkg::*;
#(
  parameter int unsigned MaxEntries = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lsch_cmd_t             cmd_i,
  output lsch_sts_t                  sts_o,
  input  wire logic [REQ_TYPE_W-1:0] req_type_i,
  input  wire logic [ENTRY_ID_W-1:0] entry_id_i,
  input  wire logic [TICKET_W-1:0]   ticket_count_i,
  input  wire logic [RND_W-1:0]      random_value_i,
  output logic [ENTRY_ID_W-1:0]      winner_id_o,
  output logic                       winner_found_o,
  output logic [TOTAL_W-1:0]         ticket_sum_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  // request registers
  logic [REQ_TYPE_W-1:0] req_q;
  logic [ENTRY_ID_W-1:0] id_q;
  logic [TICKET_W-1:0]   tk_q, tk_clamped;
  logic [RND_W-1:0]      rnd_q;

  // slot table
  logic [MaxEntries-1:0] valid_q;
  logic [TICKET_W-1:0]   mem_q [MaxEntries];
  logic [TICKET_W-1:0]   rd_data_q;
  logic                  rd_vld_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic                  pend_q;
  logic [CntW-1:0]       cnt_q;

  // draw state
  logic [TOTAL_W-1:0]    total_q;
  logic [TOTAL_W-1:0]    rem_q;
  logic [BITCNT_W-1:0]   bit_q;
  logic [TOTAL_W-1:0]    run_q;
  logic [IdxW-1:0]       win_q;
  logic                  found_q;

  // result registers
  logic [ENTRY_ID_W-1:0] res_win_q;
  logic                  res_found_q;
  logic [TOTAL_W-1:0]    res_total_q;
  logic [STATUS_W-1:0]   res_status_q;

  logic [ID_EXT_W-1:0]   id_ext, win_ext;
  logic [IdxW-1:0]       id_idx, rd_addr;
  logic                  in_range, v_sel, add_ok, rem_ok;
  logic                  issue, scan_done, div_done, hit;
  logic [TOTAL_W-1:0]    data_ext, sum_next, run_next, rem_next;
  logic [TOTAL_W:0]      trial, trial_diff;
  logic                  trial_ge;

  logic [ENTRY_ID_W-1:0] res_win_d;
  logic                  res_found_d;
  logic [TOTAL_W-1:0]    res_total_d;
  lsch_status_e          res_status_d;

  assign tk_clamped = (16'(ticket_count_i) > 16'(MAX_TICKETS)) ?
                      TICKET_W'(MAX_TICKETS) : ticket_count_i;

  assign id_ext   = ID_EXT_W'(id_q);
  assign id_idx   = id_ext[IdxW-1:0];
  assign in_range = id_ext < ID_EXT_W'(MaxEntries);
  assign v_sel    = in_range && valid_q[id_idx];
  assign add_ok   = (req_q == REQ_ADD) && in_range && !v_sel;
  assign rem_ok   = (req_q == REQ_REMOVE) && v_sel;

  assign rd_addr   = cnt_q[IdxW-1:0];
  assign issue     = cmd_i.scan_run && (cnt_q != CntW'(MaxEntries));
  assign scan_done = (cnt_q == CntW'(MaxEntries)) && !pend_q;
  assign data_ext  = TOTAL_W'(rd_data_q);
  assign sum_next  = total_q + data_ext;
  assign run_next  = run_q + data_ext;
  assign hit       = rem_q < run_next;

  // restoring modulo, one dividend bit per cycle
  assign div_done   = (bit_q == BITCNT_W'(RND_W));
  assign trial      = {rem_q, rnd_q[RND_W-1]};
  assign trial_ge   = trial >= {1'b0, total_q};
  assign trial_diff = trial - {1'b0, total_q};
  assign rem_next   = trial_ge ? trial_diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];

  assign win_ext = ID_EXT_W'(win_q);

  always_comb begin
    res_win_d    = '0;
    res_found_d  = 1'b0;
    res_total_d  = '0;
    res_status_d = ST_OK;
    unique case (req_q)
      REQ_ADD: begin
        priority if (!in_range) res_status_d = ST_ABSENT;
        else if (v_sel)         res_status_d = ST_USED;
        else                    res_status_d = ST_OK;
      end
      REQ_REMOVE: res_status_d = rem_ok ? ST_OK : ST_ABSENT;
      REQ_DRAW: begin
        if (total_q == '0) begin
          res_status_d = ST_EMPTY;
        end else begin
          res_win_d   = found_q ? win_ext[ENTRY_ID_W-1:0] : '0;
          res_found_d = found_q;
          res_total_d = total_q;
        end
      end
      default: res_status_d = ST_OK;
    endcase
  end

  assign sts_o.is_draw    = (req_q == REQ_DRAW);
  assign sts_o.scan_done  = scan_done;
  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.found      = found_q;

  assign winner_id_o     = res_win_q;
  assign winner_found_o  = res_found_q;
  assign ticket_sum_o    = res_total_q;
  assign status_o        = res_status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load && add_ok) begin
      mem_q[id_idx] <= tk_q;
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      id_q    <= entry_id_i;
      tk_q    <= tk_clamped;
      rnd_q   <= random_value_i;
      total_q <= '0;
      rem_q   <= '0;
    end else begin
      // sum pass only; reads of the walk pass must not count
      if (cmd_i.scan_run && !cmd_i.walk && pend_q && rd_vld_q) begin
        total_q <= sum_next;
      end
      if (cmd_i.div_run && !div_done) begin
        rem_q <= rem_next;
        rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
      end
    end
    if (issue) begin
      rd_idx_q <= rd_addr;
    end
    if (cmd_i.scan_start) begin
      run_q <= '0;
      win_q <= '0;
    end else if (cmd_i.walk && pend_q && rd_vld_q && !found_q) begin
      run_q <= run_next;
      if (hit) begin
        win_q <= rd_idx_q;
      end
    end
    if (cmd_i.result_load) begin
      res_win_q    <= res_win_d;
      res_found_q  <= res_found_d;
      res_total_q  <= res_total_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      bit_q    <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.result_load && add_ok) begin
        valid_q[id_idx] <= 1'b1;
      end else if (cmd_i.result_load && rem_ok) begin
        valid_q[id_idx] <= 1'b0;
      end
      if (cmd_i.load) begin
        bit_q <= '0;
      end else if (cmd_i.div_run && !div_done) begin
        bit_q <= bit_q + BITCNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        cnt_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else begin
        pend_q <= issue;
        if (issue) begin
          cnt_q    <= cnt_q + CntW'(1);
          rd_vld_q <= valid_q[rd_addr];
        end
        if (cmd_i.walk && pend_q && rd_vld_q && !found_q && hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/lottery_scheduler.sv @@
// Lottery scheduler: a table of MAX_ENTRIES process slots, each with a valid
// mark and a ticket count, driven by one request channel and one response
// channel (valid/ready, a transfer when both are high).
// Requests: add (fill a free slot), remove (clear a used slot), draw (sum the
// tickets of valid slots, reduce random_value modulo the sum, walk running
// sums in slot order to name the winner). Each request gives one response.
// Order of work: add, remove and unknown requests go from acceptance through
// a dispatch state and a finish state to response valid. A draw makes one
// pass over the ticket memory to sum, a bit-serial modulo, and a second pass
// that stops at the winner; an empty draw skips the modulo and the second
// pass. The ticket memory read, one slot per cycle, and the one-bit-per-cycle
// modulo pace these steps.
// Throughput: one request at a time; the next request is taken as soon as
// the response of the previous one sits in the output register.
// Reset clears all valid marks; no clearing pass is needed.
// When the receiver stalls, the response holds in the output register; the
// block may take and work on one more request, then waits to deliver it.
`default_nettype none

module lottery_scheduler
  import lsch_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lsch_req_if.sink    req_i,
  lsch_rsp_if.source  rsp_o
);

  lsch_cmd_t cmd;
  lsch_sts_t sts;

  lsch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lsch_dp #(
    .MaxEntries (MAX_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_i.req_type),
    .entry_id_i      (req_i.entry_id),
    .ticket_count_i  (req_i.ticket_count),
    .random_value_i  (req_i.random_value),
    .winner_id_o     (rsp_o.winner_id),
    .winner_found_o  (rsp_o.winner_found),
    .ticket_sum_o    (rsp_o.ticket_sum),
    .status_o        (rsp_o.status)
  );

endmodule

`default_nettype wire

@@ sv/lsch_chk.sv @@
`default_nettype none

module lsch_chk
  import lsch_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  rsp_valid_i,
  input wire logic                  rsp_ready_i,
  input wire logic [ENTRY_ID_W-1:0] winner_id_i,
  input wire logic                  winner_found_i,
  input wire logic [TOTAL_W-1:0]    ticket_sum_i,
  input wire logic [STATUS_W-1:0]   status_i
);

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && winner_found_i |-> status_i == ST_OK && ticket_sum_i != '0)
    else $error("winner reported without a non-empty ok draw");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_EMPTY |-> !winner_found_i && ticket_sum_i == '0)
    else $error("empty draw reports tickets or a winner");

  a_no_win_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !winner_found_i |-> winner_id_i == '0)
    else $error("winner id set without a winner");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(winner_id_i)
      && $stable(winner_found_i) && $stable(ticket_sum_i) && $stable(status_i))
    else $error("stalled response changed");

endmodule

bind lottery_scheduler lsch_chk u_lsch_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .winner_id_i     (rsp_o.winner_id),
  .winner_found_i  (rsp_o.winner_found),
  .ticket_sum_i    (rsp_o.ticket_sum),
  .status_i        (rsp_o.status)
);

`default_nettype wire
